/* hw/rtl/wav_header_parser_defines.svh */
// Assertion macros used by the checker file.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wav_header_parser check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wav_header_parser check failed");

`endif

/* hw/rtl/whp_pkg.sv */
`default_nettype none
package whp_pkg;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_SKIP,
    PH_FMT_BODY,
    PH_FMT_CHECK,
    PH_DAT_HDR,
    PH_DAT_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE = 3'd1;
  localparam logic [2:0] ST_BAD_FMT  = 3'd2;
  localparam logic [2:0] ST_NO_FMT   = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM       = 16'd1;
  localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
  localparam logic [41:0] MS_PER_S      = 42'd1000;
  localparam int          DIV_STEPS     = 42;

  // One parsed file, handed from the front to the back.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channels;
    logic [15:0] bits_per_sample;
    logic [31:0] sample_freq;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] byte_rate;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/whp_front.sv */
`default_nettype none
module whp_front import whp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire queue_stat_t q_stat,
  output logic             push,
  output job_t             push_job
);

  phase_t      phase_r, phase_nxt, phase_adv;
  logic [3:0]  cnt_r;
  logic [31:0] pos_r;
  logic [31:0] skip_r;
  logic [31:0] tag_r;
  logic [31:0] word_r;
  logic [15:0] comp_r, ch_r, align_r, bits_r;
  logic [31:0] rate_r, brate_r;
  logic        last_r;

  logic        acc;
  logic [31:0] word_full;
  logic [31:0] skip_dec;
  logic [47:0] rate_prod;
  logic [28:0] align_need;
  logic        fmt_ok;
  logic        res_valid;
  logic [2:0]  res_code;
  logic        res_last;

  assign acc        = in_valid && in_ready;
  assign word_full  = {in_data_byte, word_r[23:0]};
  assign skip_dec   = skip_r - 32'd1;
  assign rate_prod  = 48'(rate_r) * 48'(align_r);
  assign align_need = 29'(bits_r[15:3]) * 29'(ch_r);
  assign fmt_ok     = (comp_r == FMT_PCM) && (rate_prod == {16'd0, brate_r}) &&
                      (align_need == {13'd0, align_r});

  // Where parsing goes when the current byte yields no result.
  always_comb begin
    phase_adv = phase_r;
    unique case (phase_r)
      PH_RIFF:     if (acc && cnt_r == 4'd11) phase_adv = PH_FMT_HDR;
      PH_FMT_HDR: begin
        if (acc && cnt_r == 4'd7) begin
          if (tag_r == TAG_FMT) phase_adv = PH_FMT_BODY;
          else if (word_full != 32'd0) phase_adv = PH_FMT_SKIP;
        end
      end
      PH_DAT_HDR:  if (acc && cnt_r == 4'd7 && word_full != 32'd0) phase_adv = PH_DAT_SKIP;
      PH_FMT_SKIP: if (acc && skip_dec == 32'd0) phase_adv = PH_FMT_HDR;
      PH_DAT_SKIP: if (acc && skip_dec == 32'd0) phase_adv = PH_DAT_HDR;
      PH_FMT_BODY: if (acc && cnt_r == 4'd15) phase_adv = PH_FMT_CHECK;
      PH_FMT_CHECK: begin
        if (!q_stat.full) phase_adv = (skip_r != 32'd0) ? PH_DAT_SKIP : PH_DAT_HDR;
      end
      PH_DONE:     phase_adv = PH_DONE;
      default:     phase_adv = PH_RIFF;
    endcase
  end

  // Result decision for this cycle.
  always_comb begin
    res_valid = 1'b0;
    res_code  = ST_OK;
    res_last  = in_last_byte;
    unique case (phase_r)
      PH_RIFF: begin
        if (acc && cnt_r == 4'd11 && (tag_r != TAG_RIFF || word_full != TAG_WAVE)) begin
          res_valid = 1'b1;
          res_code  = ST_NOT_WAVE;
        end
      end
      PH_FMT_HDR: begin
        if (acc && cnt_r == 4'd7 && tag_r == TAG_FMT && word_full < FMT_MIN_SIZE) begin
          res_valid = 1'b1;
          res_code  = ST_BAD_FMT;
        end
      end
      PH_DAT_HDR: begin
        if (acc && cnt_r == 4'd7 && tag_r == TAG_DATA) begin
          res_valid = 1'b1;
          res_code  = ST_OK;
        end
      end
      PH_FMT_CHECK: begin
        res_last = last_r;
        if (!q_stat.full && !fmt_ok) begin
          res_valid = 1'b1;
          res_code  = ST_BAD_FMT;
        end else if (!q_stat.full && last_r) begin
          res_valid = 1'b1;
          res_code  = ST_NO_DATA;
        end
      end
      default: ;
    endcase
    // The file ends before a result: the status follows the parse phase.
    if (!res_valid && acc && in_last_byte && phase_r != PH_DONE &&
        phase_adv != PH_FMT_CHECK) begin
      res_valid = 1'b1;
      if (phase_adv == PH_RIFF) res_code = ST_NOT_WAVE;
      else if (phase_adv == PH_FMT_HDR || phase_adv == PH_FMT_SKIP ||
               phase_adv == PH_FMT_BODY) res_code = ST_NO_FMT;
      else res_code = ST_NO_DATA;
    end
  end

  always_comb begin
    phase_nxt = phase_adv;
    if (res_valid) phase_nxt = res_last ? PH_RIFF : PH_DONE;
    else if (phase_r == PH_DONE && acc && in_last_byte) phase_nxt = PH_RIFF;
  end

  always_comb begin
    in_ready = (phase_r != PH_FMT_CHECK) && !q_stat.full;
    push     = res_valid;
    push_job.status          = res_code;
    push_job.channels        = ch_r;
    push_job.bits_per_sample = bits_r;
    push_job.sample_freq     = rate_r;
    push_job.data_offset     = pos_r + 32'd1;
    push_job.data_size       = word_full;
    push_job.byte_rate       = brate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      cnt_r   <= 4'd0;
      pos_r   <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      if (phase_nxt == PH_RIFF && (res_valid || phase_r == PH_DONE)) begin
        cnt_r <= 4'd0;
        pos_r <= 32'd0;
      end else begin
        if (acc && phase_r != PH_DONE) pos_r <= pos_r + 32'd1;
        if (acc && (phase_r == PH_RIFF || phase_r == PH_FMT_HDR ||
                    phase_r == PH_DAT_HDR || phase_r == PH_FMT_BODY)) begin
          if ((phase_r == PH_RIFF && cnt_r == 4'd11) ||
              (phase_r != PH_RIFF && phase_r != PH_FMT_BODY && cnt_r == 4'd7))
            cnt_r <= 4'd0;
          else
            cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  // Field bytes, chunk sizes and skip counts, stored from accepted bytes by parse phase.
  always_ff @(posedge clk) begin
    if (acc) begin
      last_r <= in_last_byte;
      unique case (phase_r)
        PH_RIFF, PH_FMT_HDR, PH_DAT_HDR: begin
          if (cnt_r < 4'd4) tag_r[cnt_r[1:0]*8 +: 8] <= in_data_byte;
          else word_r[cnt_r[1:0]*8 +: 8] <= in_data_byte;
          if (phase_r == PH_FMT_HDR && cnt_r == 4'd7)
            skip_r <= (tag_r == TAG_FMT) ? word_full - FMT_MIN_SIZE : word_full;
          if (phase_r == PH_DAT_HDR && cnt_r == 4'd7) skip_r <= word_full;
        end
        PH_FMT_SKIP, PH_DAT_SKIP: skip_r <= skip_dec;
        PH_FMT_BODY: begin
          case (cnt_r[3:2])
            2'd0: begin
              if (!cnt_r[1]) comp_r[cnt_r[0]*8 +: 8] <= in_data_byte;
              else ch_r[cnt_r[0]*8 +: 8] <= in_data_byte;
            end
            2'd1: rate_r[cnt_r[1:0]*8 +: 8] <= in_data_byte;
            2'd2: brate_r[cnt_r[1:0]*8 +: 8] <= in_data_byte;
            default: begin
              if (!cnt_r[1]) align_r[cnt_r[0]*8 +: 8] <= in_data_byte;
              else bits_r[cnt_r[0]*8 +: 8] <= in_data_byte;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/whp_queue.sv */
`default_nettype none
module whp_queue import whp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head_job,
  output queue_stat_t q_stat
);

  job_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head_job     = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

/* hw/rtl/whp_back.sv */
`default_nettype none
module whp_back import whp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire queue_stat_t q_stat,
  input  wire job_t        head_job,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_channels,
  output logic [15:0]      out_bits_per_sample,
  output logic [31:0]      out_sample_freq,
  output logic [31:0]      out_data_offset,
  output logic [31:0]      out_data_size,
  output logic [31:0]      out_duration_ms
);

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [41:0] dvd_r, quo_r;
  logic [32:0] rem_r;
  logic [5:0]  step_r;
  logic [31:0] dur_r;
  logic        load;
  logic        out_valid_r;

  logic [32:0] rem_sh, rem_sub;
  logic        take;
  logic [41:0] quo_nxt;
  logic        last_step;
  logic        is_ok;

  assign rem_sh    = {rem_r[31:0], dvd_r[41]};
  assign rem_sub   = rem_sh - {1'b0, job_r.byte_rate};
  assign take      = (rem_sh >= {1'b0, job_r.byte_rate});
  assign quo_nxt   = {quo_r[40:0], take};
  assign last_step = (step_r == 6'(DIV_STEPS - 1));
  assign is_ok     = (job_r.status == ST_OK);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          if (head_job.status != ST_OK || head_job.byte_rate == 32'd0) state_nxt = BK_DONE;
          else state_nxt = BK_MUL;
        end
      end
      BK_MUL:  state_nxt = BK_DIV;
      BK_DIV:  if (last_step) state_nxt = BK_DONE;
      BK_DONE: if (load) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state_r == BK_IDLE) && !q_stat.empty;
    load = (state_r == BK_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          job_r <= head_job;
          dur_r <= (head_job.byte_rate == 32'd0) ? 32'hFFFF_FFFF : 32'd0;
        end
      end
      BK_MUL: begin
        dvd_r  <= 42'(job_r.data_size) * MS_PER_S;
        rem_r  <= 33'd0;
        quo_r  <= 42'd0;
        step_r <= 6'd0;
      end
      BK_DIV: begin
        dvd_r  <= {dvd_r[40:0], 1'b0};
        rem_r  <= take ? rem_sub : rem_sh;
        quo_r  <= quo_nxt;
        step_r <= step_r + 6'd1;
        if (last_step) dur_r <= (|quo_nxt[41:32]) ? 32'hFFFF_FFFF : quo_nxt[31:0];
      end
      default: ;
    endcase
    if (load) begin
      out_status          <= job_r.status;
      out_channels        <= is_ok ? job_r.channels : 16'd0;
      out_bits_per_sample <= is_ok ? job_r.bits_per_sample : 16'd0;
      out_sample_freq     <= is_ok ? job_r.sample_freq : 32'd0;
      out_data_offset     <= is_ok ? job_r.data_offset : 32'd0;
      out_data_size       <= is_ok ? job_r.data_size : 32'd0;
      out_duration_ms     <= is_ok ? dur_r : 32'd0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hw/rtl/wav_header_parser.sv */
// Channel | Signals                                         | Direction
// in      | in_valid, in_ready, in_data_byte, in_last_byte  | file bytes in
// out     | out_valid, out_ready, out_status ... duration   | one result per file
//
// The front takes one file byte per cycle while the queue has room; after the
// sixteenth fmt body byte it holds in_ready low while it validates fmt, until
// the queue has room. For a valid file with a nonzero byte rate the back
// takes the queued entry, forms size*1000, runs 42 bit-serial division steps
// and loads the output register to raise out_valid; every other file goes
// from taking the entry straight to loading the output register. A valid
// file is at least 44 bytes long, so the two-entry queue hides the division
// behind parsing; runs of very short failing files fill the queue and stall
// the front. Reset (rst_n low, synchronous) returns the front to the RIFF
// tag and empties the queue and output register. A stalled output only stops
// the front once the queue is full.
`default_nettype none
module wav_header_parser import whp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_channels,
  output logic [15:0]      out_bits_per_sample,
  output logic [31:0]      out_sample_freq,
  output logic [31:0]      out_data_offset,
  output logic [31:0]      out_data_size,
  output logic [31:0]      out_duration_ms
);

  // Results travel from the byte parser to the divider through a short queue,
  // one transaction per parsed file.
  queue_stat_t q_stat;
  logic        push, pop;
  job_t        push_job, head_job;

  whp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last_byte,
    .q_stat, .push, .push_job
  );

  whp_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head_job, .q_stat
  );

  whp_back u_back (
    .clk, .rst_n, .q_stat, .head_job, .pop, .out_valid, .out_ready,
    .out_status, .out_channels, .out_bits_per_sample, .out_sample_freq,
    .out_data_offset, .out_data_size, .out_duration_ms
  );

endmodule
`default_nettype wire

/* hw/rtl/whp_checker.sv */
`default_nettype none
`include "wav_header_parser_defines.svh"
module whp_checker import whp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_channels,
  input wire logic [15:0] out_bits_per_sample,
  input wire logic [31:0] out_sample_freq,
  input wire logic [31:0] out_data_offset,
  input wire logic [31:0] out_data_size,
  input wire logic [31:0] out_duration_ms
);

  logic is_fail;

  assign is_fail = out_valid && (out_status != ST_OK);

  `WHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_duration_ms))
  `WHP_ASSERT_NOW(a_status_range, out_valid, out_status <= ST_NO_DATA)
  `WHP_ASSERT_NOW(a_fail_zero, is_fail, ~|{out_channels, out_bits_per_sample, out_data_size})
  `WHP_ASSERT_NOW(a_fail_fmt_zero, is_fail, ~|{out_sample_freq, out_data_offset, out_duration_ms})

endmodule

bind wav_header_parser whp_checker u_whp_checker (.*);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
`default_nettype none

// One header result, as predicted or as observed on the output channel.
typedef struct {
  logic [2:0]  status;
  logic [15:0] channels;
  logic [15:0] bits_per_sample;
  logic [31:0] sample_freq;
  logic [31:0] data_offset;
  logic [31:0] data_size;
  logic [31:0] duration_ms;
} header_info_t;

// Scoreboard: carries its own copy of the header parser state. Each accepted
// byte transaction advances it, and any header result it predicts is queued.
class wav_scoreboard;
  header_info_t pending_headers[$];
  int errors;
  int headers_seen;
  int status_seen[5];

  // Tracked parser state.
  int unsigned phase;
  logic [31:0] position;
  logic [31:0] field_idx;
  logic [31:0] to_skip;
  logic [15:0] channels;
  logic [31:0] rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] bits;
  logic [15:0] compression;
  logic [31:0] tag;
  logic [31:0] word;
  bit done;

  localparam int unsigned P_RIFF = 0, P_FMT_HDR = 1, P_FMT_SKIP = 2, P_FMT_BODY = 3,
                          P_DAT_HDR = 4, P_DAT_SKIP = 5;

  function new();
    errors = 0;
    headers_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    restart();
  endfunction

  function void restart();
    phase = P_RIFF;
    position = 0;
    to_skip = 0;
    channels = 0;
    rate = 0;
    byte_rate = 0;
    block_align = 0;
    bits = 0;
    compression = 0;
    done = 0;
    field_idx = 0;
    tag = 0;
    word = 0;
  endfunction

  function logic [31:0] playtime(logic [31:0] size, logic [31:0] br);
    logic [63:0] q;
    if (br == 0) return 32'hFFFF_FFFF;
    q = ({32'd0, size} * 64'd1000) / {32'd0, br};
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Notes one accepted byte transaction.
  function void note_byte(logic [7:0] b, logic last);
    int code;
    logic [31:0] n, sz, dsize, doff, t;
    logic [63:0] prod;
    logic [31:0] need;
    bit in_fmt;
    header_info_t h;
    code = -1;
    dsize = 0;
    doff = 0;
    n = field_idx & 32'hF;
    if (done) begin
      if (last) restart();
      return;
    end
    case (phase)
      P_RIFF: begin
        if (n < 4) tag |= {24'd0, b} << (8 * n);
        else if (n >= 8) word |= {24'd0, b} << (8 * (n - 8));
        field_idx = n + 1;
        if (n == 11) begin
          if (tag != whp_pkg::TAG_RIFF || word != whp_pkg::TAG_WAVE) begin
            code = whp_pkg::ST_NOT_WAVE;
          end else begin
            phase = P_FMT_HDR;
            field_idx = 0; tag = 0; word = 0;
          end
        end
      end
      P_FMT_HDR, P_DAT_HDR: begin
        if (n < 4) tag |= {24'd0, b} << (8 * n);
        else word |= {24'd0, b} << (8 * ((n - 4) & 3));
        field_idx = n + 1;
        if (n == 7) begin
          in_fmt = (phase == P_FMT_HDR);
          sz = word;
          t = tag;
          field_idx = 0; tag = 0; word = 0;
          if (in_fmt && t == whp_pkg::TAG_FMT) begin
            if (sz < 16) begin
              code = whp_pkg::ST_BAD_FMT;
            end else begin
              to_skip = sz - 16;
              phase = P_FMT_BODY;
            end
          end else if (!in_fmt && t == whp_pkg::TAG_DATA) begin
            code = whp_pkg::ST_OK;
            dsize = sz;
            doff = position + 1;
          end else begin
            to_skip = sz;
            if (sz != 0) phase = in_fmt ? P_FMT_SKIP : P_DAT_SKIP;
          end
        end
      end
      P_FMT_SKIP, P_DAT_SKIP: begin
        to_skip--;
        if (to_skip == 0) phase = (phase == P_FMT_SKIP) ? P_FMT_HDR : P_DAT_HDR;
      end
      P_FMT_BODY: begin
        if (n < 2) compression |= {8'd0, b} << (8 * n);
        else if (n < 4) channels |= {8'd0, b} << (8 * (n - 2));
        else if (n < 8) rate |= {24'd0, b} << (8 * (n - 4));
        else if (n < 12) byte_rate |= {24'd0, b} << (8 * (n - 8));
        else if (n < 14) block_align |= {8'd0, b} << (8 * (n - 12));
        else bits |= {8'd0, b} << (8 * (n - 14));
        field_idx = n + 1;
        if (n == 15) begin
          prod = {32'd0, rate} * {48'd0, block_align};
          need = {19'd0, bits[15:3]} * {16'd0, channels};
          field_idx = 0; tag = 0; word = 0;
          if (compression != whp_pkg::FMT_PCM || prod != {32'd0, byte_rate} ||
              need != {16'd0, block_align}) begin
            code = whp_pkg::ST_BAD_FMT;
          end else begin
            phase = (to_skip != 0) ? P_DAT_SKIP : P_DAT_HDR;
          end
        end
      end
      default: phase = P_RIFF;
    endcase
    position++;
    if (code < 0 && last) begin
      if (phase == P_RIFF) code = whp_pkg::ST_NOT_WAVE;
      else if (phase == P_FMT_HDR || phase == P_FMT_SKIP || phase == P_FMT_BODY)
        code = whp_pkg::ST_NO_FMT;
      else code = whp_pkg::ST_NO_DATA;
    end
    if (code < 0) return;
    h.status = code[2:0];
    if (code == whp_pkg::ST_OK) begin
      h.channels = channels;
      h.bits_per_sample = bits;
      h.sample_freq = rate;
      h.data_offset = doff;
      h.data_size = dsize;
      h.duration_ms = playtime(dsize, byte_rate);
    end else begin
      h.channels = 0; h.bits_per_sample = 0; h.sample_freq = 0;
      h.data_offset = 0; h.data_size = 0; h.duration_ms = 0;
    end
    pending_headers.push_back(h);
    if (last) restart();
    else done = 1;
  endfunction

  // Compares one accepted result transaction with the oldest expectation.
  function void check_header(header_info_t got);
    header_info_t exp_h;
    if (pending_headers.size() == 0) begin
      $error("unexpected result transaction, status %0d", got.status);
      errors++;
      return;
    end
    exp_h = pending_headers.pop_front();
    headers_seen++;
    if (exp_h.status < 5) status_seen[exp_h.status]++;
    if (got.status !== exp_h.status) begin
      $error("status: expected %0d, got %0d", exp_h.status, got.status); errors++;
    end
    if (got.channels !== exp_h.channels) begin
      $error("channels: expected %0d, got %0d", exp_h.channels, got.channels); errors++;
    end
    if (got.bits_per_sample !== exp_h.bits_per_sample) begin
      $error("bits_per_sample: expected %0d, got %0d", exp_h.bits_per_sample,
             got.bits_per_sample);
      errors++;
    end
    if (got.sample_freq !== exp_h.sample_freq) begin
      $error("sample_freq: expected %0d, got %0d", exp_h.sample_freq, got.sample_freq);
      errors++;
    end
    if (got.data_offset !== exp_h.data_offset) begin
      $error("data_offset: expected %0d, got %0d", exp_h.data_offset, got.data_offset);
      errors++;
    end
    if (got.data_size !== exp_h.data_size) begin
      $error("data_size: expected %0d, got %0d", exp_h.data_size, got.data_size);
      errors++;
    end
    if (got.duration_ms !== exp_h.duration_ms) begin
      $error("duration_ms: expected %0d, got %0d", exp_h.duration_ms, got.duration_ms);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import whp_pkg::*;

  // The run is bounded by a cycle limit well above the slowest legal run:
  // every byte and every result waiting out the longest random stall, plus
  // the division latency of the back end per file.
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_channels;
  logic [15:0] out_bits_per_sample;
  logic [31:0] out_sample_freq;
  logic [31:0] out_data_offset;
  logic [31:0] out_data_size;
  logic [31:0] out_duration_ms;

  wav_scoreboard wav_sb;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;

  // Idle percentages for each side, changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // One file under construction, byte by byte.
  logic [7:0] file_bytes[$];

  always #1 clk = ~clk;

  wav_header_parser i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_channels        (out_channels),
    .out_bits_per_sample (out_bits_per_sample),
    .out_sample_freq     (out_sample_freq),
    .out_data_offset     (out_data_offset),
    .out_data_size       (out_data_size),
    .out_duration_ms     (out_duration_ms)
  );

  // Sampling at the rising edge: a transaction on either channel is taken when
  // valid and ready are both high. Both monitors read values that settled before
  // the edge (the bench drives its side at falling edges), so event order within the step is irrelevant.
  always @(posedge clk) begin
    header_info_t got;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && in_ready) begin
      wav_sb.note_byte(in_data_byte, in_last_byte);
    end
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.channels = out_channels;
      got.bits_per_sample = out_bits_per_sample;
      got.sample_freq = out_sample_freq;
      got.data_offset = out_data_offset;
      got.data_size = out_data_size;
      got.duration_ms = out_duration_ms;
      wav_sb.check_header(got);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: errors");
      $finish;
    end
  end

  // The receiver stalls at random, changing its ready only at falling edges.
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one byte transaction, with an optional random gap before it. Valid
  // stays high until the byte is taken; with no gap the next byte replaces it
  // at the following falling edge, and a gap or the drain drops valid.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the queued file; the final byte is marked as last.
  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_half(input logic [15:0] h);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endtask

  task automatic put_filler(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Builds an fmt chunk (tag, size and body) from its fields; extra bytes follow the first 16.
  task automatic put_fmt(input logic [15:0] comp, input logic [15:0] ch,
                         input logic [31:0] sr, input logic [31:0] br,
                         input logic [15:0] ba, input logic [15:0] bps,
                         input int unsigned extra);
    put_word(TAG_FMT);
    put_word(32'd16 + extra);
    put_half(comp);
    put_half(ch);
    put_word(sr);
    put_word(br);
    put_half(ba);
    put_half(bps);
    put_filler(extra);
  endtask

  // Builds a random file. Most are well formed with random content, with
  // occasional damage so every error status and early end is reached.
  task automatic build_random_file();
    logic [15:0] ch, bps, ba;
    logic [31:0] sr, br, dsz;
    int unsigned kind, extra;
    kind = $urandom_range(99);
    put_word((kind == 0) ? $urandom() : TAG_RIFF);
    put_word($urandom());
    put_word((kind == 1) ? $urandom() : TAG_WAVE);
    if ($urandom_range(3) == 0) begin
      put_word($urandom_range(1) ? TAG_DATA : $urandom());
      extra = $urandom_range(6);
      put_word(extra);
      put_filler(extra);
    end
    ch = $urandom_range(1) ? 16'($urandom_range(8)) : 16'($urandom());
    bps = $urandom_range(1) ? 16'(8 * $urandom_range(4)) : 16'($urandom());
    sr = $urandom_range(1) ? $urandom_range(8000, 192000) : $urandom();
    ba = 16'(32'(bps >> 3) * ch);
    br = sr * ba;
    dsz = $urandom_range(1) ? $urandom_range(1000000) : $urandom();
    if (kind == 2) begin
      put_word(TAG_FMT);
      put_word($urandom_range(15));
    end else begin
      put_fmt((kind == 3) ? 16'($urandom()) : FMT_PCM, ch, sr,
              (kind == 4) ? $urandom() : br, (kind == 5) ? 16'($urandom()) : ba, bps,
              $urandom_range(3) == 0 ? $urandom_range(4) : 0);
      if ($urandom_range(3) == 0) begin
        put_word($urandom_range(1) ? TAG_FMT : $urandom());
        extra = $urandom_range(5);
        put_word(extra);
        put_filler(extra);
      end
      if (kind != 6) begin
        put_word(TAG_DATA);
        put_word(dsz);
        // Some sample bytes after the header are ignored by the parser.
        put_filler($urandom_range(3));
      end
    end
    // Early end: cut the file short at a random point.
    if (kind >= 7 && kind < 12) begin
      while (file_bytes.size() > 1 && $urandom_range(3) != 0) void'(file_bytes.pop_back());
    end
    // Pure noise now and then.
    if (kind == 12) begin
      file_bytes.delete();
      put_filler($urandom_range(1, 20));
    end
  endtask

  // Drops valid, waits until every expected result has come back, then a
  // short drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (wav_sb.pending_headers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    wav_sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed files: a clean header, each error status, zero byte rate
    // saturation, a short fmt chunk, a chunk ending at the file's end, and
    // single-byte files.
    put_word(TAG_RIFF); put_word(32'hFFFF_FFFF); put_word(TAG_WAVE);
    put_fmt(FMT_PCM, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16, 0);
    put_word(TAG_DATA); put_word(32'd1000);
    file_bytes.push_back(8'hFF);
    send_file();
    // Zero byte rate: rate, align and bits all zero still validate.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_fmt(FMT_PCM, 16'hFFFF, 32'd0, 32'd0, 16'd0, 16'd0, 2);
    put_word(TAG_DATA); put_word(32'hFFFF_FFFF);
    send_file();
    // Duration saturation at a byte rate of one.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_fmt(FMT_PCM, 16'd1, 32'd1, 32'd1, 16'd1, 16'd8, 0);
    put_word(TAG_DATA); put_word(32'hFFFF_FFFF);
    send_file();
    // Not a WAVE file.
    put_word(TAG_RIFF); put_word(0); put_word(32'h0000_0000);
    send_file();
    // Short fmt chunk.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_word(TAG_FMT); put_word(32'd15); put_filler(4);
    send_file();
    // Non-PCM compression.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_fmt(16'hFFFF, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'd8, 0);
    send_file();
    // No fmt chunk: a skipped chunk ends exactly at the end of the file.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_word(TAG_DATA); put_word(32'd3); put_filler(3);
    send_file();
    // No data chunk after a valid fmt.
    put_word(TAG_RIFF); put_word(0); put_word(TAG_WAVE);
    put_fmt(FMT_PCM, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 0);
    put_word(TAG_FMT); put_word(32'd2); put_filler(2);
    send_file();
    // Single-byte files of both extreme values.
    file_bytes.push_back(8'h00); send_file();
    file_bytes.push_back(8'hFF); send_file();
    wait_drained();

    // Random files under four idling regimes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 57 : 37) : 0;
      recv_stall_pct = (ph == 2) ? 57 : ((ph == 3) ? 37 : 0);
      for (int f = 0; f < 4; f++) begin
        build_random_file();
        send_file();
      end
      wait_drained();
    end

    $display("sent %0d files in %0d bytes; checked %0d results", files_sent, bytes_sent,
             wav_sb.headers_seen);
    $display("status mix ok/not-wave/bad-fmt/no-fmt/no-data: %0d/%0d/%0d/%0d/%0d",
             wav_sb.status_seen[0], wav_sb.status_seen[1], wav_sb.status_seen[2],
             wav_sb.status_seen[3], wav_sb.status_seen[4]);
    if (wav_sb.errors == 0 && wav_sb.pending_headers.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
